FILE: hw/rtl/pcm_pkg.sv
// Package for the perspective coordinate map.
// Holds the fixed field widths, register index codes and the divider flag type.
// No dependencies.
package pcm_pkg;

    localparam int IN_W   = 16;
    localparam int COEF_W = 32;
    localparam int OUT_W  = 24;
    localparam int DIM_W  = 14;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;

    typedef enum logic [2:0] {
        REG_X_TERMS  = 3'd0,
        REG_X_OFFSET = 3'd1,
        REG_Y_TERMS  = 3'd2,
        REG_Y_OFFSET = 3'd3,
        REG_W_TERMS  = 3'd4,
        REG_W_OFFSET = 3'd5,
        REG_WIDTH    = 3'd6,
        REG_HEIGHT   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic zero;
    } t_div_flags;

endpackage

FILE: hw/rtl/pcm_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Carries the sign and exception flags of each item alongside the data.
// Depends on pcm_pkg.
module pcm_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 48,
    parameter int QUO_W = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [NUM_W-1:0]      i_num,
    input  logic [DEN_W-1:0]      i_den,
    input  pcm_pkg::t_div_flags   i_flags,
    output logic                  o_valid,
    output logic [QUO_W-1:0]      o_quo,
    output logic                  o_rem_nz,
    output pcm_pkg::t_div_flags   o_flags
);
    import pcm_pkg::*;

    localparam int CW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic             r_vld [1:QUO_W];
    logic [CW-1:0]    r_rem [1:QUO_W];
    logic [DEN_W-1:0] r_den [1:QUO_W];
    logic [QUO_W-1:0] r_quo [1:QUO_W];
    t_div_flags       r_flg [1:QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        localparam int BIT = QUO_W - 1 - k;
        logic             s_vld;
        logic [CW-1:0]    s_rem;
        logic [DEN_W-1:0] s_den;
        logic [QUO_W-1:0] s_quo;
        t_div_flags       s_flg;
        logic [CW-1:0]    s_shift;
        logic             s_ge;
        logic [CW-1:0]    n_rem;
        logic [QUO_W-1:0] n_quo;

        if (k == 0) begin : g_first
            assign s_vld = i_valid;
            assign s_rem = CW'(i_num);
            assign s_den = i_den;
            assign s_quo = '0;
            assign s_flg = i_flags;
        end else begin : g_next
            assign s_vld = r_vld[k];
            assign s_rem = r_rem[k];
            assign s_den = r_den[k];
            assign s_quo = r_quo[k];
            assign s_flg = r_flg[k];
        end

        always_comb begin
            s_shift = CW'(s_den) << BIT;
            s_ge = s_rem >= s_shift;
            n_rem = s_ge ? (s_rem - s_shift) : s_rem;
            n_quo = s_quo;
            n_quo[BIT] = s_ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= n_rem;
                r_den[k+1] <= s_den;
                r_quo[k+1] <= n_quo;
                r_flg[k+1] <= s_flg;
            end
        end
    end

    assign o_valid  = r_vld[QUO_W];
    assign o_quo    = r_quo[QUO_W];
    assign o_rem_nz = |r_rem[QUO_W];
    assign o_flags  = r_flg[QUO_W];

endmodule

FILE: hw/rtl/perspective_coordinate_map.sv
// Top level of the perspective coordinate map with its register file.
// Depends on pcm_pkg and pcm_div.
//
// Each input item is a signed destination pixel (dest_x, dest_y). It is mapped
// through the inverse homography held in the registers, and the result item gives
// the source position with SRC_FRAC_BITS fraction bits, rounded toward minus
// infinity, and a flag that is set when the point lies inside the source image.
// Both channels use valid and ready. The block takes one item in every cycle in
// which in_ready is high. The pipeline registers, in order, the products, the
// row sums, the magnitudes, the range check, the stages of the one-bit-per-stage
// dividers and then rounding, saturation and the output register.
// When the receiver stalls, the whole pipeline holds and in_ready falls in the
// same cycle, so no item is lost or repeated.
// Reset empties the pipeline and loads the identity matrix and a 640 x 480 source.
// The APB port reads and writes the registers at byte address 8*i; registers are
// to be written only while no item is in flight; the block does not enforce this.
module perspective_coordinate_map #(
    parameter int COEF_FRAC_BITS = 16,
    parameter int SRC_FRAC_BITS  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [pcm_pkg::IN_W-1:0]   i_dest_x,
    input  logic signed [pcm_pkg::IN_W-1:0]   i_dest_y,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [pcm_pkg::OUT_W-1:0]  o_source_x,
    output logic signed [pcm_pkg::OUT_W-1:0]  o_source_y,
    output logic                              o_inside_res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pcm_pkg::ADDR_W-1:0]        paddr,
    input  logic [pcm_pkg::DATA_W-1:0]        pwdata,
    output logic [pcm_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);
    import pcm_pkg::*;

    localparam int PROD_W = COEF_W + IN_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MAG_W  = PROD_W;
    localparam int NUM_W  = MAG_W + SRC_FRAC_BITS;
    localparam int CW     = (NUM_W > MAG_W + OUT_W) ? NUM_W : MAG_W + OUT_W;
    localparam int LIM_W  = DIM_W + SRC_FRAC_BITS;
    localparam int CMP_W  = (LIM_W > OUT_W) ? LIM_W + 1 : OUT_W + 1;
    localparam logic [COEF_W-1:0] ONE = COEF_W'(1) << COEF_FRAC_BITS;
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Register file.
    logic [DATA_W-1:0] r_x_terms, r_y_terms, r_w_terms;
    logic [COEF_W-1:0] r_x_offset, r_y_offset, r_w_offset;
    logic [DIM_W-1:0]  r_width, r_height;
    t_reg_idx          reg_idx;
    logic              wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[ADDR_W-1:3]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_terms  <= DATA_W'(ONE);
            r_x_offset <= '0;
            r_y_terms  <= {ONE, {COEF_W{1'b0}}};
            r_y_offset <= '0;
            r_w_terms  <= '0;
            r_w_offset <= ONE;
            r_width    <= DIM_W'(640);
            r_height   <= DIM_W'(480);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_X_TERMS:  r_x_terms  <= pwdata;
                REG_X_OFFSET: r_x_offset <= pwdata[COEF_W-1:0];
                REG_Y_TERMS:  r_y_terms  <= pwdata;
                REG_Y_OFFSET: r_y_offset <= pwdata[COEF_W-1:0];
                REG_W_TERMS:  r_w_terms  <= pwdata;
                REG_W_OFFSET: r_w_offset <= pwdata[COEF_W-1:0];
                REG_WIDTH:    r_width    <= pwdata[DIM_W-1:0];
                REG_HEIGHT:   r_height   <= pwdata[DIM_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_X_TERMS:  prdata = r_x_terms;
            REG_X_OFFSET: prdata = DATA_W'(r_x_offset);
            REG_Y_TERMS:  prdata = r_y_terms;
            REG_Y_OFFSET: prdata = DATA_W'(r_y_offset);
            REG_W_TERMS:  prdata = r_w_terms;
            REG_W_OFFSET: prdata = DATA_W'(r_w_offset);
            REG_WIDTH:    prdata = DATA_W'(r_width);
            REG_HEIGHT:   prdata = DATA_W'(r_height);
        endcase
    end

    // Global advance: every stage moves when the output register can move.
    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // Stage 1: six products.
    logic signed [COEF_W-1:0] c_hxx, c_hxy, c_hyx, c_hyy, c_hwx, c_hwy;
    assign c_hxx = r_x_terms[COEF_W-1:0];
    assign c_hxy = r_x_terms[DATA_W-1:COEF_W];
    assign c_hyx = r_y_terms[COEF_W-1:0];
    assign c_hyy = r_y_terms[DATA_W-1:COEF_W];
    assign c_hwx = r_w_terms[COEF_W-1:0];
    assign c_hwy = r_w_terms[DATA_W-1:COEF_W];

    logic r_v1, r_v2, r_v3, r_v4;
    logic signed [PROD_W-1:0] r_pxx, r_pxy, r_pyx, r_pyy, r_pwx, r_pwy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxx <= c_hxx * i_dest_x;
            r_pxy <= c_hxy * i_dest_y;
            r_pyx <= c_hyx * i_dest_x;
            r_pyy <= c_hyy * i_dest_y;
            r_pwx <= c_hwx * i_dest_x;
            r_pwy <= c_hwy * i_dest_y;
        end
    end

    // Stage 2: row sums.
    logic signed [SUM_W-1:0] r_nx, r_ny, r_w;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nx <= SUM_W'(r_pxx) + SUM_W'(r_pxy) + SUM_W'(signed'(r_x_offset));
            r_ny <= SUM_W'(r_pyx) + SUM_W'(r_pyy) + SUM_W'(signed'(r_y_offset));
            r_w  <= SUM_W'(r_pwx) + SUM_W'(r_pwy) + SUM_W'(signed'(r_w_offset));
        end
    end

    // Stage 3: magnitudes and signs.
    logic [SUM_W-1:0] abs_nx, abs_ny, abs_w;
    logic [NUM_W-1:0] r_num_x, r_num_y;
    logic [MAG_W-1:0] r_den;
    logic             r_neg_x, r_neg_y, r_zero;

    always_comb begin
        abs_nx = r_nx[SUM_W-1] ? (~r_nx + 1'b1) : r_nx;
        abs_ny = r_ny[SUM_W-1] ? (~r_ny + 1'b1) : r_ny;
        abs_w  = r_w[SUM_W-1]  ? (~r_w + 1'b1)  : r_w;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_x <= {abs_nx[MAG_W-1:0], {SRC_FRAC_BITS{1'b0}}};
            r_num_y <= {abs_ny[MAG_W-1:0], {SRC_FRAC_BITS{1'b0}}};
            r_den   <= abs_w[MAG_W-1:0];
            r_neg_x <= r_nx[SUM_W-1] ^ r_w[SUM_W-1];
            r_neg_y <= r_ny[SUM_W-1] ^ r_w[SUM_W-1];
            r_zero  <= (r_w == '0);
        end
    end

    // Stage 4: quotient range check.
    logic [CW-1:0]    den_top;
    logic [NUM_W-1:0] r_num4_x, r_num4_y;
    logic [MAG_W-1:0] r_den4;
    t_div_flags       r_flg_x, r_flg_y;

    assign den_top = CW'(r_den) << OUT_W;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num4_x     <= r_num_x;
            r_num4_y     <= r_num_y;
            r_den4       <= r_den;
            r_flg_x.neg  <= r_neg_x;
            r_flg_x.ovf  <= CW'(r_num_x) >= den_top;
            r_flg_x.zero <= r_zero;
            r_flg_y.neg  <= r_neg_y;
            r_flg_y.ovf  <= CW'(r_num_y) >= den_top;
            r_flg_y.zero <= r_zero;
        end
    end

    // Dividers.
    logic             dv_valid, dv_valid_y;
    logic [OUT_W-1:0] dq_x, dq_y;
    logic             drn_x, drn_y;
    t_div_flags       df_x, df_y;

    pcm_div #(.NUM_W(NUM_W), .DEN_W(MAG_W), .QUO_W(OUT_W)) u_div_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_v4),
        .i_num    (r_num4_x),
        .i_den    (r_den4),
        .i_flags  (r_flg_x),
        .o_valid  (dv_valid),
        .o_quo    (dq_x),
        .o_rem_nz (drn_x),
        .o_flags  (df_x)
    );

    pcm_div #(.NUM_W(NUM_W), .DEN_W(MAG_W), .QUO_W(OUT_W)) u_div_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (r_v4),
        .i_num    (r_num4_y),
        .i_den    (r_den4),
        .i_flags  (r_flg_y),
        .o_valid  (dv_valid_y),
        .o_quo    (dq_y),
        .o_rem_nz (drn_y),
        .o_flags  (df_y)
    );

    // Final stage: floor rounding, saturation, the inside test and the zero w result.
    logic [OUT_W:0]   qc_x, qc_y;
    logic             ov_x, ov_y, in_x, in_y;
    logic [OUT_W-1:0] n_sx, n_sy;
    logic             n_inside;
    logic [CMP_W-1:0] lim_w, lim_h;

    always_comb begin
        qc_x  = {1'b0, dq_x} + (OUT_W+1)'(drn_x);
        qc_y  = {1'b0, dq_y} + (OUT_W+1)'(drn_y);
        lim_w = CMP_W'(r_width) << SRC_FRAC_BITS;
        lim_h = CMP_W'(r_height) << SRC_FRAC_BITS;
        if (df_x.neg) begin
            ov_x = df_x.ovf || (qc_x > (OUT_W+1)'(OUT_MIN));
            n_sx = ov_x ? OUT_MIN : OUT_W'(~qc_x + 1'b1);
        end else begin
            ov_x = df_x.ovf || dq_x[OUT_W-1];
            n_sx = ov_x ? OUT_MAX : dq_x;
        end
        if (df_y.neg) begin
            ov_y = df_y.ovf || (qc_y > (OUT_W+1)'(OUT_MIN));
            n_sy = ov_y ? OUT_MIN : OUT_W'(~qc_y + 1'b1);
        end else begin
            ov_y = df_y.ovf || dq_y[OUT_W-1];
            n_sy = ov_y ? OUT_MAX : dq_y;
        end
        in_x = (!df_x.neg || (qc_x == '0)) && (CMP_W'(dq_x) < lim_w);
        in_y = (!df_y.neg || (qc_y == '0)) && (CMP_W'(dq_y) < lim_h);
        n_inside = !ov_x && !ov_y && in_x && in_y;
        if (df_x.zero) begin
            n_sx     = '0;
            n_sy     = '0;
            n_inside = 1'b0;
        end
    end

    logic             r_out_valid;
    logic [OUT_W-1:0] r_sx, r_sy;
    logic             r_inside, r_out_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx       <= n_sx;
            r_sy       <= n_sy;
            r_inside   <= n_inside;
            r_out_zero <= df_x.zero;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_source_x   = r_sx;
    assign o_source_y   = r_sy;
    assign o_inside_res = r_inside;

    a_inside_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_inside |-> !r_sx[OUT_W-1] && !r_sy[OUT_W-1])
        else $error("inside flag set on a negative source coordinate");

    a_zero_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_zero |-> r_sx == '0 && r_sy == '0 && !r_inside)
        else $error("zero w item did not give a zero result");

    a_inside_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_inside |->
            (CMP_W'(r_sx) < (CMP_W'(r_width) << SRC_FRAC_BITS)) &&
            (CMP_W'(r_sy) < (CMP_W'(r_height) << SRC_FRAC_BITS)))
        else $error("inside flag set beyond the source image");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_sx) && $stable(r_inside))
        else $error("stalled result item changed");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_valid == dv_valid_y)
        else $error("dividers out of step");

endmodule
